/* rtl/padcd_pkg.sv */
package padcd_pkg;

    // Default sample width of one channel.
    localparam int SAMPLE_BITS_DEF = 8;

    // Configuration register widths.
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 3;
    localparam int CFG_DATA_W = 3;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCARD_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT  = 2'd2;

    // Color mode codes. Any other code passes samples through.
    localparam logic [MODE_W-1:0] MODE_PASS      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_YCOCG     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB_GREEN = 2'd2;

    // Reset value of the channel count and the largest meaningful count.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]  color_mode;
        logic               discard_enable;
        logic [COUNT_W-1:0] channel_count;
    } t_cfg;

endpackage

/* rtl/pixel_alpha_discard_color_decorrelate.sv */
// Pixel alpha discard and color decorrelation. Each input transaction carries one pixel of
// up to four unsigned samples; each output transaction carries one pixel of four planes:
// plane 0 and plane 3 unsigned, planes 1 and 2 signed and one bit wider than a sample.
// If discard is enabled and the pixel's alpha (channel 1 for two channels, channel 3 for
// four) is zero, the color channels below alpha are zeroed. For three or more channels,
// color mode 1 applies the reversible YCoCg-R lifting transform (Y, Co, Cg) and mode 2
// the subtract-green transform (G, R-G, B-G); other modes pass samples through. Channels
// at or beyond the channel count come out as zero, and a count above four acts as four.
// The block takes one pixel every clock cycle while it does not stall. An accepted
// pixel lands in an input register, crosses the transform logic, and is held in a
// result register until the downstream side takes it. The input side stalls
// only when both registers are full and the output is stalled. Configuration registers
// are written through a simple write port and must only change while the block is idle.
module pixel_alpha_discard_color_decorrelate #(
    parameter int SAMPLE_BITS = padcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_we,
    input  logic [padcd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [padcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [SAMPLE_BITS-1:0]               i_chan_zero,
    input  logic [SAMPLE_BITS-1:0]               i_chan_one,
    input  logic [SAMPLE_BITS-1:0]               i_chan_two,
    input  logic [SAMPLE_BITS-1:0]               i_chan_three,

    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [SAMPLE_BITS-1:0]               o_out_zero,
    output logic signed [SAMPLE_BITS:0]          o_out_one,
    output logic signed [SAMPLE_BITS:0]          o_out_two,
    output logic [SAMPLE_BITS-1:0]               o_out_three
);

    // Configuration registers.
    padcd_pkg::t_cfg r_cfg;

    // Input register stage.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_zero, r_in_one, r_in_two, r_in_three;

    // Result register stage.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_zero, r_out_three;
    logic signed [SAMPLE_BITS:0] r_out_one, r_out_two;

    // Transform results for the pixel in the input register.
    logic [SAMPLE_BITS-1:0]      n_out_zero, n_out_three;
    logic signed [SAMPLE_BITS:0] n_out_one, n_out_two;

    logic out_load;
    logic in_load;

    // The result register can take a new pixel when it is empty or its pixel leaves now.
    assign out_load = !r_out_valid || !i_stall;
    // The input register can take a new pixel when it is empty or its pixel moves on.
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode     <= padcd_pkg::MODE_PASS;
            r_cfg.discard_enable <= 1'b0;
            r_cfg.channel_count  <= padcd_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                padcd_pkg::REG_COLOR_MODE:
                    r_cfg.color_mode <= i_cfg_data[padcd_pkg::MODE_W-1:0];
                padcd_pkg::REG_DISCARD_ENABLE:
                    r_cfg.discard_enable <= i_cfg_data[0];
                padcd_pkg::REG_CHANNEL_COUNT:
                    r_cfg.channel_count <= i_cfg_data[padcd_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in_zero  <= i_chan_zero;
            r_in_one   <= i_chan_one;
            r_in_two   <= i_chan_two;
            r_in_three <= i_chan_three;
        end
    end

    padcd_xform #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_xform (
        .i_cfg        (r_cfg),
        .i_chan_zero  (r_in_zero),
        .i_chan_one   (r_in_one),
        .i_chan_two   (r_in_two),
        .i_chan_three (r_in_three),
        .o_out_zero   (n_out_zero),
        .o_out_one    (n_out_one),
        .o_out_two    (n_out_two),
        .o_out_three  (n_out_three)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out_zero  <= n_out_zero;
            r_out_one   <= n_out_one;
            r_out_two   <= n_out_two;
            r_out_three <= n_out_three;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_zero  = r_out_zero;
    assign o_out_one   = r_out_one;
    assign o_out_two   = r_out_two;
    assign o_out_three = r_out_three;

endmodule

/* rtl/padcd_xform.sv */
module padcd_xform #(
    parameter int SAMPLE_BITS = padcd_pkg::SAMPLE_BITS_DEF
) (
    input  padcd_pkg::t_cfg               i_cfg,
    input  logic [SAMPLE_BITS-1:0]        i_chan_zero,
    input  logic [SAMPLE_BITS-1:0]        i_chan_one,
    input  logic [SAMPLE_BITS-1:0]        i_chan_two,
    input  logic [SAMPLE_BITS-1:0]        i_chan_three,
    output logic [SAMPLE_BITS-1:0]        o_out_zero,
    output logic signed [SAMPLE_BITS:0]   o_out_one,
    output logic signed [SAMPLE_BITS:0]   o_out_two,
    output logic [SAMPLE_BITS-1:0]        o_out_three
);

    localparam int W  = SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + 2;

    logic [padcd_pkg::COUNT_W-1:0] n;
    logic [W-1:0]  c0, c1, c2, c3;
    logic          has_alpha;
    logic          alpha_zero;
    logic          do_xform;
    logic signed [DW-1:0] r, g, b;
    logic signed [DW-1:0] co, co_half, temp, cg, cg_half, y;
    logic signed [DW-1:0] rg, bg;

    always_comb begin
        n = (i_cfg.channel_count > padcd_pkg::COUNT_MAX) ? padcd_pkg::COUNT_MAX
                                                         : i_cfg.channel_count;

        // Channels at or beyond the count read as zero.
        c0 = (n > 3'd0) ? i_chan_zero  : '0;
        c1 = (n > 3'd1) ? i_chan_one   : '0;
        c2 = (n > 3'd2) ? i_chan_two   : '0;
        c3 = (n > 3'd3) ? i_chan_three : '0;

        // Alpha sits in channel 1 for two channels and channel 3 for four.
        has_alpha  = (n == 3'd2) || (n == 3'd4);
        alpha_zero = (n == 3'd2) ? (c1 == '0) : (c3 == '0);
        if (i_cfg.discard_enable && has_alpha && alpha_zero) begin
            c0 = '0;
            if (n == 3'd4) begin
                c1 = '0;
                c2 = '0;
            end
        end

        r = $signed({2'b00, c0});
        g = $signed({2'b00, c1});
        b = $signed({2'b00, c2});

        // Lifting steps; a halving adds the sign bit first so it truncates toward zero.
        co      = r - b;
        co_half = $signed(co + {{(DW-1){1'b0}}, co[DW-1]}) >>> 1;
        temp    = b + co_half;
        cg      = g - temp;
        cg_half = $signed(cg + {{(DW-1){1'b0}}, cg[DW-1]}) >>> 1;
        y       = temp + cg_half;

        rg = r - g;
        bg = b - g;

        do_xform = (n >= 3'd3);

        o_out_zero  = c0;
        o_out_one   = $signed({1'b0, c1});
        o_out_two   = $signed({1'b0, c2});
        o_out_three = c3;
        if (do_xform) begin
            case (i_cfg.color_mode)
                padcd_pkg::MODE_YCOCG: begin
                    o_out_zero = y[W-1:0];
                    o_out_one  = co[W:0];
                    o_out_two  = cg[W:0];
                end
                padcd_pkg::MODE_SUB_GREEN: begin
                    o_out_zero = c1;
                    o_out_one  = rg[W:0];
                    o_out_two  = bg[W:0];
                end
                default: begin
                    o_out_zero = c0;
                end
            endcase
        end
    end

endmodule
